>>> design/ipv6_address_compressor_core_macros.svh
// Assertion macros used by the checker file of the IPv6 address compressor.
`ifndef IPV6_ADDRESS_COMPRESSOR_CORE_MACROS_SVH
`define IPV6_ADDRESS_COMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPV6AC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define IPV6AC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

>>> design/ipv6ac_pkg.sv
// Shared types, constants and helper functions of the IPv6 address compressor.
package ipv6ac_pkg;

	localparam int GROUPS     = 8;
	localparam int GRP_W      = 16;
	localparam int IDX_W      = 3;
	localparam int CHAR_W     = 8;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

	typedef logic [GRP_W-1:0]  group_t;
	typedef logic [CHAR_W-1:0] char_t;

	// One classified address: the groups and the zero run chosen for "::".
	typedef struct packed {
		group_t [GROUPS-1:0] grp;
		logic                has_run;
		logic [IDX_W-1:0]    run_start;
		logic [IDX_W:0]      run_end;
	} addr_item_t;

	// Position of the most significant non-zero nibble, zero for a zero group.
	function automatic logic [1:0] lead_nibble(input group_t g);
		logic [1:0] idx;
		idx = 2'd0;
		if (g[7:4] != 4'd0) idx = 2'd1;
		if (g[11:8] != 4'd0) idx = 2'd2;
		if (g[15:12] != 4'd0) idx = 2'd3;
		return idx;
	endfunction

endpackage

>>> design/ipv6ac_if.sv
// Channel interfaces: address requests in, text characters out.
interface ipv6ac_addr_if;
	logic                 valid;
	logic                 ready;
	ipv6ac_pkg::group_t   group_0;
	ipv6ac_pkg::group_t   group_1;
	ipv6ac_pkg::group_t   group_2;
	ipv6ac_pkg::group_t   group_3;
	ipv6ac_pkg::group_t   group_4;
	ipv6ac_pkg::group_t   group_5;
	ipv6ac_pkg::group_t   group_6;
	ipv6ac_pkg::group_t   group_7;

	modport source (output valid, group_0, group_1, group_2, group_3,
		group_4, group_5, group_6, group_7, input ready);
	modport sink (input valid, group_0, group_1, group_2, group_3,
		group_4, group_5, group_6, group_7, output ready);
endinterface

interface ipv6ac_text_if;
	logic                valid;
	logic                ready;
	ipv6ac_pkg::char_t   text_char;
	logic                last_char;

	modport source (output valid, text_char, last_char, input ready);
	modport sink (input valid, text_char, last_char, output ready);
endinterface

>>> design/ipv6ac_front.sv
// Front end: accepts address requests and finds the first longest zero run.
module ipv6ac_front (
	ipv6ac_addr_if.sink          addr,
	input  logic                 full,
	output logic                 push,
	output ipv6ac_pkg::addr_item_t item
);

	logic [ipv6ac_pkg::IDX_W:0]   run_len;
	logic [ipv6ac_pkg::IDX_W:0]   best_len;
	logic [ipv6ac_pkg::IDX_W-1:0] run_start;
	logic [ipv6ac_pkg::IDX_W-1:0] best_start;
	ipv6ac_pkg::group_t [ipv6ac_pkg::GROUPS-1:0] grp;

	assign addr.ready = !full;
	assign push       = addr.valid && !full;

	assign grp[0] = addr.group_0;
	assign grp[1] = addr.group_1;
	assign grp[2] = addr.group_2;
	assign grp[3] = addr.group_3;
	assign grp[4] = addr.group_4;
	assign grp[5] = addr.group_5;
	assign grp[6] = addr.group_6;
	assign grp[7] = addr.group_7;

	// Scan the groups once; a run only replaces the best when strictly longer.
	always_comb begin
		run_len    = '0;
		best_len   = '0;
		run_start  = '0;
		best_start = '0;
		for (int i = 0; i < ipv6ac_pkg::GROUPS; i++) begin
			if (grp[i] == '0) begin
				if (run_len == '0) run_start = ipv6ac_pkg::IDX_W'(i);
				run_len = run_len + 1'b1;
				if (run_len > best_len) begin
					best_len   = run_len;
					best_start = run_start;
				end
			end else begin
				run_len = '0;
			end
		end
	end

	always_comb begin
		item.grp       = grp;
		item.has_run   = (best_len != '0);
		item.run_start = best_start;
		item.run_end   = {1'b0, best_start} + best_len;
	end

endmodule

>>> design/ipv6ac_fifo.sv
// Two-entry queue of classified addresses between front and back end.
module ipv6ac_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  ipv6ac_pkg::addr_item_t push_item,
	output logic                   full,
	input  logic                   pop,
	output ipv6ac_pkg::addr_item_t pop_item,
	output logic                   empty
);

	ipv6ac_pkg::addr_item_t                  store_q [ipv6ac_pkg::FIFO_DEPTH];
	logic [ipv6ac_pkg::FIFO_PTR_W-1:0]       wr_ptr_q;
	logic [ipv6ac_pkg::FIFO_PTR_W-1:0]       rd_ptr_q;
	logic [ipv6ac_pkg::FIFO_CNT_W-1:0]       count_q;

	assign full     = (count_q == ipv6ac_pkg::FIFO_CNT_W'(ipv6ac_pkg::FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> design/ipv6ac_back.sv
// Back end: walks one classified address and sends its text a character a cycle while text.ready does not stall it.
module ipv6ac_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   empty,
	output logic                   pop,
	input  ipv6ac_pkg::addr_item_t pop_item,
	ipv6ac_text_if.source          text
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_GROUP  = 4'b0010,
		ST_DIGIT  = 4'b0100,
		ST_DCOLON = 4'b1000
	} seq_state_t;

	localparam ipv6ac_pkg::char_t CHAR_ZERO  = 8'h30;
	localparam ipv6ac_pkg::char_t CHAR_ALPHA = 8'h57;
	localparam logic [ipv6ac_pkg::IDX_W-1:0] LAST_GROUP = ipv6ac_pkg::IDX_W'(ipv6ac_pkg::GROUPS - 1);

	seq_state_t                   state_q, state_d;
	ipv6ac_pkg::addr_item_t       item_q;
	logic [ipv6ac_pkg::IDX_W-1:0] gidx_q, gidx_d;
	logic [1:0]                   nib_q, nib_d;
	logic                         out_valid_q;
	ipv6ac_pkg::char_t            out_char_q;
	logic                         out_last_q;

	logic                         advance;
	logic                         emit;
	ipv6ac_pkg::char_t            emit_char;
	logic                         emit_last;
	ipv6ac_pkg::group_t           cur_grp;
	logic [1:0]                   lead;
	logic [1:0]                   sel_nib;
	logic [3:0]                   dig;
	ipv6ac_pkg::char_t            dig_char;
	logic                         need_sep;

	assign advance     = !out_valid_q || text.ready;
	assign text.valid     = out_valid_q;
	assign text.text_char = out_char_q;
	assign text.last_char = out_last_q;

	assign cur_grp  = item_q.grp[gidx_q];
	assign lead     = ipv6ac_pkg::lead_nibble(cur_grp);
	assign sel_nib  = (state_q == ST_DIGIT) ? nib_q : lead;
	assign dig      = 4'(cur_grp >> {sel_nib, 2'b00});
	assign dig_char = (dig < 4'd10) ? CHAR_ZERO + 8'(dig) : CHAR_ALPHA + 8'(dig);
	// The group right after the compressed run follows "::" with no separator.
	assign need_sep = (item_q.has_run && gidx_q == item_q.run_start) ||
		(gidx_q != '0 && !(item_q.has_run && {1'b0, gidx_q} == item_q.run_end));

	always_comb begin
		state_d   = state_q;
		gidx_d    = gidx_q;
		nib_d     = nib_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_char = CHAR_ZERO;
		emit_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (advance && !empty) begin
					pop     = 1'b1;
					gidx_d  = '0;
					state_d = ST_GROUP;
				end
			end
			ST_GROUP, ST_DIGIT: begin
				emit = 1'b1;
				if (state_q == ST_GROUP && item_q.has_run && gidx_q == item_q.run_start) begin
					emit_char = ipv6ac_pkg::CHAR_COLON;
					state_d   = ST_DCOLON;
				end else if (state_q == ST_GROUP && need_sep) begin
					emit_char = ipv6ac_pkg::CHAR_COLON;
					nib_d     = lead;
					state_d   = ST_DIGIT;
				end else begin
					emit_char = dig_char;
					if (sel_nib == 2'd0) begin
						if (gidx_q == LAST_GROUP) begin
							emit_last = 1'b1;
							state_d   = ST_IDLE;
						end else begin
							gidx_d  = gidx_q + 1'b1;
							state_d = ST_GROUP;
						end
					end else begin
						nib_d   = sel_nib - 1'b1;
						state_d = ST_DIGIT;
					end
				end
			end
			ST_DCOLON: begin
				emit      = 1'b1;
				emit_char = ipv6ac_pkg::CHAR_COLON;
				if (item_q.run_end[ipv6ac_pkg::IDX_W]) begin
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					gidx_d  = item_q.run_end[ipv6ac_pkg::IDX_W-1:0];
					state_d = ST_GROUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= pop_item;
		if (advance && emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gidx_q      <= '0;
			nib_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_d;
			gidx_q      <= gidx_d;
			nib_q       <= nib_d;
			out_valid_q <= emit;
		end
	end

endmodule

>>> design/ipv6_address_compressor_core.sv
// IPv6 address compressor: turns eight 16-bit groups into compressed text, one
// character per output request. Each address request on addr is classified in
// the same cycle it is accepted (the first longest run of zero groups is found,
// a single zero group counting as a run) and placed in a two-entry queue, so
// addr.ready stays high while fewer than two addresses wait. The back end takes
// one address at a time from the queue: it loads the address, then sends its
// 2 to 39 characters in turn through the single character output register.
// Characters are lower-case hex digits and colons; leading zeros are dropped,
// a zero group prints as 0 and the chosen run prints as ::. last_char marks
// the final character of each address. Stalls on text.ready hold the output
// register and the sequencer; the front end keeps filling the queue meanwhile.
module ipv6_address_compressor_core (
	input  logic          clk,
	input  logic          arst_n,
	ipv6ac_addr_if.sink   addr,
	ipv6ac_text_if.source text
);

	// Queue handshake between the classifier and the sequencer.
	logic                   push;
	logic                   full;
	logic                   pop;
	logic                   empty;
	ipv6ac_pkg::addr_item_t push_item;
	ipv6ac_pkg::addr_item_t pop_item;

	// Classifier: accepts a request whenever the queue has room.
	ipv6ac_front u_front (
		.addr (addr),
		.full (full),
		.push (push),
		.item (push_item)
	);

	// Decouples the accept side from the character stream.
	ipv6ac_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	// Sequencer and output register: emits the text of one address.
	ipv6ac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.pop      (pop),
		.pop_item (pop_item),
		.text     (text)
	);

endmodule

>>> design/ipv6ac_checker.sv
// Port-level checker for the IPv6 address compressor, bound to the top level.
`include "ipv6_address_compressor_core_macros.svh"

module ipv6ac_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              addr_valid,
	input logic              addr_ready,
	input logic              text_valid,
	input logic              text_ready,
	input ipv6ac_pkg::char_t text_char,
	input logic              last_char
);

	logic       in_acc;
	logic       out_acc;
	logic       is_colon;
	logic [2:0] pending_q;
	logic       prev1_colon_q;
	logic       prev2_colon_q;

	assign in_acc   = addr_valid && addr_ready;
	assign out_acc  = text_valid && text_ready;
	assign is_colon = (text_char == ipv6ac_pkg::CHAR_COLON);

	// Addresses accepted whose final character has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= '0;
			prev1_colon_q <= 1'b0;
			prev2_colon_q <= 1'b0;
		end else begin
			if (in_acc && !(out_acc && last_char)) pending_q <= pending_q + 1'b1;
			else if (!in_acc && out_acc && last_char) pending_q <= pending_q - 1'b1;
			if (out_acc) begin
				prev1_colon_q <= is_colon && !last_char;
				prev2_colon_q <= prev1_colon_q && !last_char;
			end
		end
	end

	`IPV6AC_ASSERT_NEXT(a_hold_stalled, text_valid && !text_ready, text_valid && $stable(text_char) && $stable(last_char))
	`IPV6AC_ASSERT_SAME(a_char_set, text_valid, (text_char >= 8'h30 && text_char <= 8'h39) || (text_char >= 8'h61 && text_char <= 8'h66) || is_colon)
	`IPV6AC_ASSERT_SAME(a_no_triple_colon, out_acc && prev1_colon_q && prev2_colon_q, !is_colon)
	`IPV6AC_ASSERT_SAME(a_text_has_owner, text_valid, pending_q != 3'd0)
	`IPV6AC_ASSERT_SAME(a_pending_bound, 1'b1, pending_q <= 3'd3)

endmodule

bind ipv6_address_compressor_core ipv6ac_checker u_ipv6ac_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.addr_valid (addr.valid),
	.addr_ready (addr.ready),
	.text_valid (text.valid),
	.text_ready (text.ready),
	.text_char  (text.text_char),
	.last_char  (text.last_char)
);
